[rtl/core/char_lcd_write_sequencer_core_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the character LCD write sequencer core
// Implication checks, clocked on the rising edge and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef CHAR_LCD_WRITE_SEQUENCER_CORE_ASSERT_SVH
`define CHAR_LCD_WRITE_SEQUENCER_CORE_ASSERT_SVH

// Consequence must hold in the same cycle as the antecedent
`define CLWS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("clws same-cycle check failed");

// Consequence must hold in the cycle after the antecedent
`define CLWS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("clws next-cycle check failed");

`endif

[rtl/core/clws_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clws_pkg
// Shared types and constants of the character LCD write sequencer.
// ----------------------------------------------------------------------------
package clws_pkg;

	// Request kinds
	localparam logic [2:0] FUNC_DATA   = 3'd0;
	localparam logic [2:0] FUNC_CMD    = 3'd1;
	localparam logic [2:0] FUNC_CURSOR = 3'd2;
	localparam logic [2:0] FUNC_DEC    = 3'd3;
	localparam logic [2:0] FUNC_INIT   = 3'd4;

	// Configuration register indexes
	localparam logic [2:0] CFG_EIGHT_BIT_BUS = 3'd0;
	localparam logic [2:0] CFG_TWO_LINES     = 3'd1;
	localparam logic [2:0] CFG_LARGE_FONT    = 3'd2;
	localparam logic [2:0] CFG_DISPLAY_ON    = 3'd3;
	localparam logic [2:0] CFG_CURSOR_ON     = 3'd4;
	localparam logic [2:0] CFG_BLINK_ON      = 3'd5;

	// LCD command and character constants
	localparam logic [7:0] FUNC_SET_BASE  = 8'h20;
	localparam logic [7:0] DISP_CTRL_BASE = 8'h08;
	localparam logic [7:0] CLEAR_CMD      = 8'h01;
	localparam logic [7:0] ASCII_ZERO     = 8'h30;
	localparam logic [5:0] INIT_WAIT_MS   = 6'd40;

	// Reciprocal of ten, scaled by 2^35
	localparam logic [31:0] RECIP_TEN = 32'hCCCC_CCCD;
	localparam int          RECIP_SHIFT = 35;

	// Defaults and sizes
	localparam int MAX_DIGITS_DEF = 10;
	localparam int QUEUE_DEPTH    = 4;
	localparam int QPTR_W         = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W         = $clog2(QUEUE_DEPTH + 1);

	// Configuration bits
	typedef struct packed {
		logic eight_bit_bus;
		logic two_lines;
		logic large_font;
		logic display_on;
		logic cursor_on;
		logic blink_on;
	} clws_cfg_t;

	// One byte job from the front to the back
	typedef struct packed {
		logic       rs;
		logic [7:0] val;
		logic [5:0] wait_ms;
		logic       last;
		logic       single;
	} clws_job_t;

endpackage

[rtl/core/clws_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clws_front
// Accepts requests, converts decimals and pushes byte jobs to the queue.
// ----------------------------------------------------------------------------
module clws_front #(
	parameter int MAX_DIGITS = clws_pkg::MAX_DIGITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  clws_pkg::clws_cfg_t cfg,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [2:0]          func,
	input  logic [7:0]          byte_value,
	input  logic                row,
	input  logic [5:0]          column,
	input  logic [31:0]         number,
	output logic                push_valid,
	output clws_pkg::clws_job_t push_job,
	input  logic                q_full
);
	import clws_pkg::*;

	localparam int IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
	localparam int CNT_W = $clog2(MAX_DIGITS + 1);
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_DIGITS);
	localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

	typedef enum logic [2:0] {
		F_IDLE,
		F_SIMPLE,
		F_INIT,
		F_MUL,
		F_DIG,
		F_EMIT
	} front_state_t;

	front_state_t     state_q;
	clws_job_t        job_q;
	logic [1:0]       step_q;
	logic [31:0]      v_q;
	logic [28:0]      prod_q;
	logic [CNT_W-1:0] cnt_q;
	logic [3:0]       dig_q [MAX_DIGITS];

	logic             accept;
	logic [63:0]      prod_full;
	logic [31:0]      q10;
	logic [31:0]      rem_full;
	logic [CNT_W-1:0] cnt_inc;
	logic [CNT_W-1:0] cnt_dec;
	logic [7:0]       fset;
	logic [7:0]       dctl;
	clws_job_t        init_job;

	assign accept   = in_valid && !in_stall;
	assign in_stall = (state_q != F_IDLE);

	// Divide by ten: reciprocal multiply, then remainder from the quotient
	assign prod_full = v_q * RECIP_TEN;
	assign q10       = ({3'b000, prod_q} << 3) + ({3'b000, prod_q} << 1);
	assign rem_full  = v_q - q10;
	assign cnt_inc   = cnt_q + CNT_ONE;
	assign cnt_dec   = cnt_q - CNT_ONE;

	// Build init commands from the configuration
	assign fset = FUNC_SET_BASE | {3'b000, cfg.eight_bit_bus, cfg.two_lines,
		cfg.large_font, 2'b00};
	assign dctl = DISP_CTRL_BASE | {5'b00000, cfg.display_on, cfg.cursor_on,
		cfg.blink_on};

	always_comb begin
		init_job = '0;
		unique case (step_q)
			2'd0: begin
				init_job.val     = FUNC_SET_BASE;
				init_job.wait_ms = INIT_WAIT_MS;
				init_job.single  = 1'b1;
			end
			2'd1: begin
				init_job.val     = fset;
				init_job.wait_ms = cfg.eight_bit_bus ? INIT_WAIT_MS : 6'd0;
			end
			2'd2: begin
				init_job.val = dctl;
			end
			2'd3: begin
				init_job.val  = CLEAR_CMD;
				init_job.last = 1'b1;
			end
		endcase
	end

	// Select the job offered to the queue
	always_comb begin
		push_valid = 1'b0;
		push_job   = job_q;
		unique case (state_q)
			F_SIMPLE: begin
				push_valid = 1'b1;
			end
			F_INIT: begin
				push_valid = 1'b1;
				push_job   = init_job;
			end
			F_EMIT: begin
				push_valid       = 1'b1;
				push_job         = '0;
				push_job.rs      = 1'b1;
				push_job.val     = ASCII_ZERO + {4'h0, dig_q[cnt_dec[IDX_W-1:0]]};
				push_job.last    = (cnt_q == CNT_ONE);
			end
			default: begin
				push_valid = 1'b0;
			end
		endcase
	end

	// Sequence the request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			step_q  <= 2'd0;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				F_IDLE: begin
					if (accept) begin
						unique case (func)
							FUNC_DATA: begin
								job_q   <= '{rs: 1'b1, val: byte_value, wait_ms: 6'd0,
									last: 1'b1, single: 1'b0};
								state_q <= F_SIMPLE;
							end
							FUNC_CMD: begin
								job_q   <= '{rs: 1'b0, val: byte_value, wait_ms: 6'd0,
									last: 1'b1, single: 1'b0};
								state_q <= F_SIMPLE;
							end
							FUNC_CURSOR: begin
								job_q   <= '{rs: 1'b0, val: {1'b1, row, column}, wait_ms: 6'd0,
									last: 1'b1, single: 1'b0};
								state_q <= F_SIMPLE;
							end
							FUNC_DEC: begin
								v_q     <= number;
								cnt_q   <= '0;
								state_q <= F_MUL;
							end
							FUNC_INIT: begin
								step_q  <= cfg.eight_bit_bus ? 2'd1 : 2'd0;
								state_q <= F_INIT;
							end
							default: begin
								state_q <= F_IDLE;
							end
						endcase
					end
				end
				F_SIMPLE: begin
					if (!q_full) state_q <= F_IDLE;
				end
				F_INIT: begin
					if (!q_full) begin
						step_q <= step_q + 2'd1;
						if (step_q == 2'd3) state_q <= F_IDLE;
					end
				end
				F_MUL: begin
					prod_q  <= prod_full[63:RECIP_SHIFT];
					state_q <= F_DIG;
				end
				F_DIG: begin
					dig_q[cnt_q[IDX_W-1:0]] <= rem_full[3:0];
					v_q   <= {3'b000, prod_q};
					cnt_q <= cnt_inc;
					if (prod_q == '0 || cnt_inc == CNT_MAX) state_q <= F_EMIT;
					else state_q <= F_MUL;
				end
				F_EMIT: begin
					if (!q_full) begin
						cnt_q <= cnt_dec;
						if (cnt_q == CNT_ONE) state_q <= F_IDLE;
					end
				end
				default: begin
					state_q <= F_IDLE;
				end
			endcase
		end
	end

endmodule

[rtl/core/clws_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clws_queue
// Small job FIFO between the front and the back.
// ----------------------------------------------------------------------------
module clws_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push_valid,
	input  clws_pkg::clws_job_t push_job,
	output logic                full,
	input  logic                pop,
	output logic                empty,
	output clws_pkg::clws_job_t head
);
	import clws_pkg::*;

	localparam logic [QCNT_W-1:0] DEPTH_CNT = QCNT_W'(QUEUE_DEPTH);

	clws_job_t         mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              do_push;
	logic              do_pop;

	assign full    = (cnt_q == DEPTH_CNT);
	assign empty   = (cnt_q == '0);
	assign head    = mem_q[rd_q];
	assign do_push = push_valid && !full;
	assign do_pop  = pop && !empty;

	// Store pushed jobs
	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_q] <= push_job;
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) wr_q <= wr_q + QPTR_W'(1);
			if (do_pop) rd_q <= rd_q + QPTR_W'(1);
			if (do_push && !do_pop) cnt_q <= cnt_q + QCNT_W'(1);
			else if (do_pop && !do_push) cnt_q <= cnt_q - QCNT_W'(1);
		end
	end

endmodule

[rtl/core/clws_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clws_back
// Turns byte jobs into enable strobes and holds them in the output register.
// ----------------------------------------------------------------------------
module clws_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                eight_bit_bus,
	input  logic                q_empty,
	input  clws_pkg::clws_job_t q_head,
	output logic                pop,
	output logic                out_valid,
	input  logic                out_stall,
	output logic                reg_select,
	output logic [7:0]          bus_value,
	output logic [5:0]          wait_before_ms,
	output logic                last
);
	import clws_pkg::*;

	typedef enum logic [1:0] {
		B_IDLE,
		B_FIRST,
		B_SECOND
	} back_state_t;

	back_state_t state_q;
	clws_job_t   cur_q;
	logic        out_valid_q;
	logic        rs_q;
	logic [7:0]  val_q;
	logic [5:0]  wait_q;
	logic        last_q;
	logic        out_free;
	logic        two_strobe;
	logic        emit;

	assign out_free   = !out_valid_q || !out_stall;
	assign two_strobe = !eight_bit_bus && !cur_q.single;
	assign pop        = (state_q == B_IDLE) && !q_empty;
	assign emit       = ((state_q == B_FIRST) || (state_q == B_SECOND)) && out_free;

	assign out_valid      = out_valid_q;
	assign reg_select     = rs_q;
	assign bus_value      = val_q;
	assign wait_before_ms = wait_q;
	assign last           = last_q;

	// Take a job, emit its one or two strobes, drop the word once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall && !emit) out_valid_q <= 1'b0;
			unique case (state_q)
				B_IDLE: begin
					if (!q_empty) begin
						cur_q   <= q_head;
						state_q <= B_FIRST;
					end
				end
				B_FIRST: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						rs_q        <= cur_q.rs;
						val_q       <= cur_q.val;
						wait_q      <= cur_q.wait_ms;
						last_q      <= cur_q.last && !two_strobe;
						state_q     <= two_strobe ? B_SECOND : B_IDLE;
					end
				end
				B_SECOND: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						rs_q        <= cur_q.rs;
						val_q       <= {cur_q.val[3:0], 4'h0};
						wait_q      <= 6'd0;
						last_q      <= cur_q.last;
						state_q     <= B_IDLE;
					end
				end
				default: begin
					state_q <= B_IDLE;
				end
			endcase
		end
	end

endmodule

[rtl/core/char_lcd_write_sequencer_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// char_lcd_write_sequencer_core
// Character LCD bus master: requests in, one word per enable strobe out.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_stall): func selects data, command, set cursor,
// decimal print or init; byte_value, row, column and number are its operands.
// Output channel (out_valid/out_stall): one word per strobe with reg_select,
// bus_value, wait_before_ms (40 on the first strobe of an init) and last.
// Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data): bit 0 of the
// data is written; ready is always high; write only while idle.
// The front takes one request at a time and stalls until its byte jobs are
// queued; for a decimal it runs a divide-by-ten loop per digit (one multiply,
// one remainder step) and then queues the digits. A four-entry queue feeds the
// back, which takes a job from the queue only while idle and then registers
// its one or two strobes, so it takes no new job until the last strobe of the
// current one is registered. The first strobe of a simple request passes the
// front's job register, the queue, the back's job register and the output register.
// When the receiver stalls, the output word holds, the queue fills and then
// the front holds in_stall high. Reset empties the queue and output register
// and loads the configuration defaults: 8-bit bus, two lines, display on.
// ----------------------------------------------------------------------------
module char_lcd_write_sequencer_core #(
	parameter int MAX_DIGITS = clws_pkg::MAX_DIGITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  func,
	input  logic [7:0]  byte_value,
	input  logic        row,
	input  logic [5:0]  column,
	input  logic [31:0] number,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        reg_select,
	output logic [7:0]  bus_value,
	output logic [5:0]  wait_before_ms,
	output logic        last,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [7:0]  cfg_data
);
	import clws_pkg::*;

	`include "char_lcd_write_sequencer_core_assert.svh"

	clws_cfg_t cfg_q;
	logic      push_valid;
	clws_job_t push_job;
	logic      q_full;
	logic      q_empty;
	clws_job_t q_head;
	logic      pop;

	assign cfg_ready = 1'b1;

	// Hold configuration bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.eight_bit_bus <= 1'b1;
			cfg_q.two_lines     <= 1'b1;
			cfg_q.large_font    <= 1'b0;
			cfg_q.display_on    <= 1'b1;
			cfg_q.cursor_on     <= 1'b0;
			cfg_q.blink_on      <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_EIGHT_BIT_BUS: cfg_q.eight_bit_bus <= cfg_data[0];
				CFG_TWO_LINES:     cfg_q.two_lines     <= cfg_data[0];
				CFG_LARGE_FONT:    cfg_q.large_font    <= cfg_data[0];
				CFG_DISPLAY_ON:    cfg_q.display_on    <= cfg_data[0];
				CFG_CURSOR_ON:     cfg_q.cursor_on     <= cfg_data[0];
				CFG_BLINK_ON:      cfg_q.blink_on      <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	clws_front #(
		.MAX_DIGITS(MAX_DIGITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.func      (func),
		.byte_value(byte_value),
		.row       (row),
		.column    (column),
		.number    (number),
		.push_valid(push_valid),
		.push_job  (push_job),
		.q_full    (q_full)
	);

	clws_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(push_valid),
		.push_job  (push_job),
		.full      (q_full),
		.pop       (pop),
		.empty     (q_empty),
		.head      (q_head)
	);

	clws_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.eight_bit_bus (cfg_q.eight_bit_bus),
		.q_empty       (q_empty),
		.q_head        (q_head),
		.pop           (pop),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.reg_select    (reg_select),
		.bus_value     (bus_value),
		.wait_before_ms(wait_before_ms),
		.last          (last)
	);

	// Back never pops an empty queue
	`CLWS_ASSERT_SAME(a_no_pop_empty, clk, arst_n, pop, !q_empty)
	// A valid request keeps the front busy in the next cycle
	`CLWS_ASSERT_NEXT(a_busy_after_req, clk, arst_n,
		in_valid && !in_stall && (func == FUNC_DATA || func == FUNC_CMD ||
		func == FUNC_CURSOR || func == FUNC_DEC || func == FUNC_INIT), in_stall)
	// Only the init wait is ever reported, and only on a command strobe
	`CLWS_ASSERT_SAME(a_wait_is_init, clk, arst_n, out_valid && wait_before_ms != 6'd0,
		!reg_select && wait_before_ms == INIT_WAIT_MS && !last)
	// After a pop the queue is never full, so a pending push is not blocked
	`CLWS_ASSERT_NEXT(a_back_takes_job, clk, arst_n, pop, !q_full || !push_valid || pop)

endmodule
